### design/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg: shared constants, types and tables for the burst phase detector
// Angle units: 2^32 is one full turn. Sums are 40-bit saturating.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int unsigned SAMPLE_BITS_DEF     = 12;
  localparam int unsigned SINE_TABLE_BITS_DEF = 10;
  localparam int unsigned CORDIC_STEPS_DEF    = 16;

  localparam int unsigned PHASE_BITS     = 32;
  localparam int unsigned SUM_BITS       = 40;
  // vectoring datapath: negation of the most negative sum plus CORDIC growth
  localparam int unsigned VEC_BITS       = SUM_BITS + 3;
  localparam int unsigned ANGLE_BITS     = PHASE_BITS + 2;
  // rotation outputs stay below 1.65 * 16384 in magnitude
  localparam int unsigned ROT_BITS       = 18;
  localparam int unsigned UNIT_AMPLITUDE = 16384;
  localparam int unsigned ATAN_ENTRIES   = 24;
  localparam int unsigned ATAN_IDX_BITS  = $clog2(ATAN_ENTRIES);
  localparam int unsigned QUEUE_DEPTH    = 4;
  localparam int unsigned PHASE_OUT_BITS = 16;

  localparam logic [PHASE_BITS-1:0] PHASE_INC_RESET = 32'h4000_0000;
  localparam logic [PHASE_BITS-1:0] HALF_TURN       = 32'h8000_0000;
  localparam logic [PHASE_BITS-1:0] ROUND_HALF      = 32'h0000_8000;

  typedef enum logic [0:0] {
    MODE_ROTATE = 1'b0,
    MODE_VECTOR = 1'b1
  } bpd_mode_e;

  // what a queued item asks of the back end
  typedef struct packed {
    logic has_sample;
    logic last;
  } bpd_kind_t;

  typedef struct packed {
    logic      start;
    bpd_mode_e mode;
  } bpd_cordic_req_t;

  // atan(2^-i) in angle units
  function automatic logic [PHASE_BITS-1:0] atan_unit(input logic [ATAN_IDX_BITS-1:0] idx);
    logic [PHASE_BITS-1:0] a;
    unique case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### design/bpd_if.sv
// ----------------------------------------------------------------------------
// bpd_if: valid/ready channels of the burst phase detector
// Input items, phase results and phase increment writes.
// ----------------------------------------------------------------------------
interface bpd_in_if import bpd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          has_sample;
  logic                          last;

  modport source (output valid, sample, has_sample, last, input ready);
  modport sink   (input valid, sample, has_sample, last, output ready);
endinterface

interface bpd_out_if import bpd_pkg::*;;
  logic                             valid;
  logic                             ready;
  logic signed [PHASE_OUT_BITS-1:0] phase;

  modport source (output valid, phase, input ready);
  modport sink   (input valid, phase, output ready);
endinterface

interface bpd_cfg_if import bpd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### design/bpd_front.sv
// ----------------------------------------------------------------------------
// bpd_front: input acceptance and item queue
// Drops items that carry neither a sample nor last; queues the rest.
// ----------------------------------------------------------------------------
module bpd_front import bpd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bpd_in_if.sink                        in_i,
  output logic                          q_valid_o,
  output bpd_kind_t                     q_kind_o,
  output logic signed [SAMPLE_BITS-1:0] q_sample_o,
  input  logic                          q_pop_i
);

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);

  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_BITS:0]   count_q;
  bpd_kind_t           kind_q   [QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] sample_q [QUEUE_DEPTH];
  logic                push, pop;

  assign in_i.ready = (count_q != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready && (in_i.has_sample || in_i.last);
  assign pop        = q_pop_i && q_valid_o;

  assign q_valid_o  = (count_q != '0);
  assign q_kind_o   = kind_q[rd_ptr_q];
  assign q_sample_o = sample_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_ptr_q]   <= '{has_sample: in_i.has_sample, last: in_i.last};
      sample_q[wr_ptr_q] <= in_i.sample;
    end
  end

endmodule

### design/bpd_cordic.sv
// ----------------------------------------------------------------------------
// bpd_cordic: iterative CORDIC, rotation and vectoring
// One micro-rotation per cycle; done pulses the cycle after the last step.
// ----------------------------------------------------------------------------
module bpd_cordic import bpd_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bpd_cordic_req_t              req_i,
  input  logic signed [VEC_BITS-1:0]   x0_i,
  input  logic signed [VEC_BITS-1:0]   y0_i,
  input  logic signed [ANGLE_BITS-1:0] z0_i,
  output logic                         done_o,
  output logic signed [VEC_BITS-1:0]   x_o,
  output logic signed [VEC_BITS-1:0]   y_o,
  output logic signed [ANGLE_BITS-1:0] z_o
);

  localparam int unsigned STEP_BITS = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic                         busy_q, done_q;
  logic [STEP_BITS-1:0]         step_q;
  bpd_mode_e                    mode_q;
  logic signed [VEC_BITS-1:0]   x_q, y_q, xs, ys;
  logic signed [ANGLE_BITS-1:0] z_q, a;
  logic                         neg;

  assign xs  = x_q >>> step_q;
  assign ys  = y_q >>> step_q;
  assign a   = signed'({2'b00, atan_unit(ATAN_IDX_BITS'(step_q))});
  // rotation drives z to zero, vectoring drives y to zero
  assign neg = (mode_q == MODE_ROTATE) ? z_q[ANGLE_BITS-1]
                                       : (!y_q[VEC_BITS-1] && (y_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_BITS'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      x_q    <= x0_i;
      y_q    <= y0_i;
      z_q    <= z0_i;
    end else if (busy_q) begin
      if (neg) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + a;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - a;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

### design/bpd_back.sv
// ----------------------------------------------------------------------------
// bpd_back: burst accumulation and phase sequencer
// Runs queued items through the CORDIC, multipliers and saturating sums.
// ----------------------------------------------------------------------------
module bpd_back import bpd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  bpd_kind_t                     q_kind_i,
  input  logic signed [SAMPLE_BITS-1:0] q_sample_i,
  output logic                          q_pop_o,
  input  logic [PHASE_BITS-1:0]         phase_inc_i,
  bpd_out_if.source                     out_o
);

  localparam int unsigned PROD_BITS = SAMPLE_BITS + ROT_BITS;
  localparam logic [PHASE_BITS-1:0] TABLE_MASK =
    {{SINE_TABLE_BITS{1'b1}}, {(PHASE_BITS - SINE_TABLE_BITS){1'b0}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ROT  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_VEC  = 6'b100000
  } bpd_state_e;

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0]  sum,
    input logic signed [PROD_BITS-1:0] prod
  );
    logic signed [SUM_BITS:0] wide;
    wide = $signed({sum[SUM_BITS-1], sum}) + (SUM_BITS+1)'(prod);
    if (wide[SUM_BITS] != wide[SUM_BITS-1]) begin
      return wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end
    return wide[SUM_BITS-1:0];
  endfunction

  bpd_state_e                      state_q, state_d;
  logic [PHASE_BITS-1:0]           phase_acc_q;
  logic signed [SUM_BITS-1:0]      cos_sum_q, sin_sum_q;
  logic                            seen_q;
  logic                            out_valid_q;
  logic signed [PHASE_OUT_BITS-1:0] out_phase_q;

  logic signed [SAMPLE_BITS-1:0]   sample_q;
  logic                            last_q;
  logic [1:0]                      quad_q;
  logic signed [ROT_BITS-1:0]      c_q, s_q, c_d, s_d;
  logic signed [PROD_BITS-1:0]     prod_c_q, prod_s_q;

  logic [PHASE_BITS-1:0]           pq, resid;
  logic [1:0]                      quad;
  logic signed [VEC_BITS-1:0]      cos_ext, sin_ext, x0, y0;
  logic signed [ANGLE_BITS-1:0]    z0;
  logic signed [ROT_BITS-1:0]      xr, yr;
  logic [PHASE_BITS-1:0]           rounded;
  logic                            out_free, sums_zero, pop, start_rot, start_vec;
  logic                            finish_zero, finish_vec, clear;
  bpd_cordic_req_t                 req;
  logic                            cordic_done;
  logic signed [VEC_BITS-1:0]      cordic_x, cordic_y;
  logic signed [ANGLE_BITS-1:0]    cordic_z;

  // phase split: quadrant plus a residue within +-45 degrees
  assign pq    = phase_acc_q & TABLE_MASK;
  assign quad  = pq[PHASE_BITS-1 -: 2] + {1'b0, pq[PHASE_BITS-3]};
  assign resid = pq - {quad, {(PHASE_BITS-2){1'b0}}};

  assign cos_ext   = VEC_BITS'(cos_sum_q);
  assign sin_ext   = VEC_BITS'(sin_sum_q);
  assign sums_zero = (cos_sum_q == '0) && (sin_sum_q == '0);
  assign out_free  = !out_valid_q || out_o.ready;

  assign pop         = (state_q == ST_IDLE) && q_valid_i;
  assign start_rot   = pop && q_kind_i.has_sample;
  assign finish_zero = (state_q == ST_FIN) && out_free && (!seen_q || sums_zero);
  assign finish_vec  = (state_q == ST_VEC) && cordic_done;
  assign start_vec   = (state_q == ST_FIN) && out_free && seen_q && !sums_zero;
  assign clear       = finish_zero || finish_vec;

  always_comb begin
    if (state_q == ST_IDLE) begin
      x0 = VEC_BITS'(UNIT_AMPLITUDE);
      y0 = '0;
      z0 = ANGLE_BITS'(signed'(resid));
    end else if (cos_sum_q[SUM_BITS-1]) begin
      x0 = -cos_ext;
      y0 = -sin_ext;
      z0 = signed'({2'b00, HALF_TURN});
    end else begin
      x0 = cos_ext;
      y0 = sin_ext;
      z0 = '0;
    end
  end

  assign req.start = start_rot || start_vec;
  assign req.mode  = start_vec ? MODE_VECTOR : MODE_ROTATE;

  bpd_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .x0_i   (x0),
    .y0_i   (y0),
    .z0_i   (z0),
    .done_o (cordic_done),
    .x_o    (cordic_x),
    .y_o    (cordic_y),
    .z_o    (cordic_z)
  );

  // undo the quadrant fold
  assign xr = cordic_x[ROT_BITS-1:0];
  assign yr = cordic_y[ROT_BITS-1:0];
  always_comb begin
    case (quad_q)
      2'd0:    begin c_d = xr;  s_d = yr;  end
      2'd1:    begin c_d = -yr; s_d = xr;  end
      2'd2:    begin c_d = -xr; s_d = -yr; end
      default: begin c_d = yr;  s_d = -xr; end
    endcase
  end

  assign rounded = cordic_z[PHASE_BITS-1:0] + ROUND_HALF;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (pop) state_d = q_kind_i.has_sample ? ST_ROT : ST_FIN;
      ST_ROT:  if (cordic_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        if (finish_zero)    state_d = ST_IDLE;
        else if (start_vec) state_d = ST_VEC;
      end
      ST_VEC:  if (cordic_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_acc_q <= '0;
      cos_sum_q   <= '0;
      sin_sum_q   <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear) begin
        phase_acc_q <= '0;
        cos_sum_q   <= '0;
        sin_sum_q   <= '0;
        seen_q      <= 1'b0;
      end else if (state_q == ST_ACC) begin
        phase_acc_q <= phase_acc_q + phase_inc_i;
        cos_sum_q   <= sat_add(cos_sum_q, prod_c_q);
        sin_sum_q   <= sat_add(sin_sum_q, prod_s_q);
        seen_q      <= 1'b1;
      end
      if (clear)             out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sample_q <= q_sample_i;
      last_q   <= q_kind_i.last;
      quad_q   <= quad;
    end
    if ((state_q == ST_ROT) && cordic_done) begin
      c_q <= c_d;
      s_q <= s_d;
    end
    if (state_q == ST_MUL) begin
      prod_c_q <= sample_q * c_q;
      prod_s_q <= sample_q * s_q;
    end
    if (finish_zero) out_phase_q <= '0;
    else if (finish_vec) out_phase_q <= signed'(rounded[PHASE_BITS-1 -: PHASE_OUT_BITS]);
  end

  assign q_pop_o     = pop;
  assign out_o.valid = out_valid_q;
  assign out_o.phase = out_phase_q;

endmodule

### design/burst_phase_detector.sv
// ----------------------------------------------------------------------------
// burst_phase_detector: color-burst phase measurement
// Quadrature correlation of burst samples and atan2 of the two sums.
// ----------------------------------------------------------------------------
// Each burst sample is correlated against cosine and sine of a local phase
// that starts at zero with every burst and advances by phase_increment
// (2^32 = one turn) per sample; the item flagged last returns the burst phase
// as atan2(sine_sum, cosine_sum), 32768 = pi, and restarts the burst. Items
// go into a 4-entry queue, so the input keeps accepting while the back end
// works. The back end runs one iterative CORDIC with one step per cycle and
// takes one item at a time: a sample item passes through rotation, multiply
// and accumulate states; last on a sample item then adds a vectoring pass,
// and last on an item of its own runs that vectoring pass alone. An empty
// burst, or one whose sums are both zero, needs no vectoring: its last item
// then answers with phase 0. Items with neither a sample nor last are dropped
// on entry and cost nothing. The result waits in an output register, and
// sample items keep flowing while it waits; a last item stalls until that
// register is free. phase_increment is to be written by the user through the
// cfg channel only while no burst is in flight; the block does not enforce it.
// Its reset value 2^30 corresponds to sampling at four times the subcarrier.
// ----------------------------------------------------------------------------
module burst_phase_detector import bpd_pkg::*; #(
  parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int unsigned SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpd_in_if.sink    in_i,
  bpd_out_if.source out_o,
  bpd_cfg_if.sink   cfg_i
);

  logic [PHASE_BITS-1:0]         phase_inc_q;
  logic                          q_valid, q_pop;
  bpd_kind_t                     q_kind;
  logic signed [SAMPLE_BITS-1:0] q_sample;

  // phase increment register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q <= PHASE_INC_RESET;
    end else if (cfg_i.valid) begin
      phase_inc_q <= cfg_i.data;
    end
  end

  // front: accept and queue items
  bpd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .q_valid_o  (q_valid),
    .q_kind_o   (q_kind),
    .q_sample_o (q_sample),
    .q_pop_i    (q_pop)
  );

  // back: correlate, accumulate, resolve phase
  bpd_back #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_kind_i    (q_kind),
    .q_sample_i  (q_sample),
    .q_pop_o     (q_pop),
    .phase_inc_i (phase_inc_q),
    .out_o       (out_o)
  );

endmodule

### tb/burst_phase_detector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burst_phase_detector_test: self-checking bench for the burst phase detector
// Drives burst items and phase increment writes over the valid/ready channels,
// predicts each burst phase in-bench and checks every result item in order.
// ----------------------------------------------------------------------------
module burst_phase_detector_test;
  import bpd_pkg::*;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;
  typedef logic signed [PHASE_OUT_BITS-1:0]  phase_t;
  typedef logic        [PHASE_BITS-1:0]      turn_t;

  // which quarter turn the rotation CORDIC folds into
  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quadrant_e;

  localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_BITS_DEF - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(1 << (SAMPLE_BITS_DEF - 1)));
  localparam longint  SUM_HI     = (longint'(1) << (SUM_BITS - 1)) - 1;
  localparam longint  SUM_LO     = -(longint'(1) << (SUM_BITS - 1));

  // arctan(2^-i), one full turn = 2^32
  localparam turn_t ATAN_TURN [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81};

  // settle margin covers a full queue of 4 items, each with rotation and vectoring
  localparam int SETTLE_CYCLES = QUEUE_DEPTH * (2 * CORDIC_STEPS_DEF + 6) + 16;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpd_in_if  in_if ();
  bpd_out_if out_if ();
  bpd_cfg_if cfg_if ();

  burst_phase_detector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Burst phase predictor: local copy of the carrier phase, the two
  // correlation sums and the step size as last written.
  // --------------------------------------------------------------------------
  turn_t   carrier_step = PHASE_INC_RESET;
  turn_t   carrier_phase = '0;
  longint  cos_corr = 0;
  longint  sin_corr = 0;
  bit      burst_has_sample = 1'b0;
  phase_t  phase_due [$];

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  phase_t      want_phase;

  // cos/sin of the carrier, table-resolution phase, unscaled CORDIC gain
  function automatic void carrier_cos_sin(input turn_t ph, output longint c,
                                          output longint s);
    turn_t     top, biased, resid;
    quadrant_e quad;
    longint    x, y, z, dx, dy;
    int        i;
    top    = ph & ~((32'd1 << (PHASE_BITS - SINE_TABLE_BITS_DEF)) - 32'd1);
    biased = top + 32'h2000_0000;
    quad   = quadrant_e'(biased[31:30]);
    resid  = top - {quad, 30'd0};
    z = longint'($signed(resid));
    x = longint'(UNIT_AMPLITUDE);
    y = 0;
    for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ATAN_TURN[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ATAN_TURN[i]);
      end
    end
    case (quad)
      QUAD_0: begin
        c = x;
        s = y;
      end
      QUAD_90: begin
        c = -y;
        s = x;
      end
      QUAD_180: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
  endfunction

  // atan2(y, x) by vectoring CORDIC, 2^32 = one turn
  function automatic turn_t burst_angle(input longint x, input longint y);
    turn_t  z;
    longint dx, dy;
    int     i;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ATAN_TURN[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_TURN[i];
      end
    end
    return z;
  endfunction

  function automatic longint clamp_sum(input longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  // update the burst state for one accepted item, queue the phase on last
  function automatic void track_burst_item(input sample_t smp, input bit has,
                                           input bit fin);
    longint c, s, v;
    turn_t  rounded;
    phase_t ph;
    if (has) begin
      v = longint'(smp);
      carrier_cos_sin(carrier_phase, c, s);
      cos_corr = clamp_sum(cos_corr + v * c);
      sin_corr = clamp_sum(sin_corr + v * s);
      carrier_phase += carrier_step;
      burst_has_sample = 1'b1;
    end
    if (fin) begin
      ph = '0;
      if (burst_has_sample) begin
        rounded = burst_angle(cos_corr, sin_corr) + ROUND_HALF;
        ph = rounded[31:16];
      end
      phase_due.push_back(ph);
      carrier_phase = '0;
      cos_corr = 0;
      sin_corr = 0;
      burst_has_sample = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure and in-order checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (phase_due.size() == 0) begin
        report_mismatch($sformatf("phase %0d with no burst pending", out_if.phase));
      end else begin
        want_phase = phase_due.pop_front();
        if (out_if.phase !== want_phase)
          report_mismatch($sformatf("phase got %0d want %0d", out_if.phase, want_phase));
      end
    end
  end

  // hard stop for a hung handshake or a lost result
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Item side
  // --------------------------------------------------------------------------
  function automatic sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return SAMPLE_MAX;
    if (r == 1) return SAMPLE_MIN;
    return sample_t'($urandom_range((1 << SAMPLE_BITS_DEF) - 1));
  endfunction

  // one item; an optional random gap first, valid stays high on return
  task automatic send_item(input sample_t smp, input bit has, input bit fin);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid      <= 1'b1;
    in_if.sample     <= smp;
    in_if.has_sample <= has;
    in_if.last       <= fin;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    track_burst_item(smp, has, fin);
  endtask

  task automatic hold_until_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (phase_due.size() != 0);
  endtask

  // all results in, then let the back end finish any trailing work
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_increment(input turn_t value);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    carrier_step = value;
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned dst_pct);
    send_idle_pct  = src_pct;
    sink_stall_pct = dst_pct;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset step of a quarter turn: empty burst, zero sums, near-pi wrap,
  // both quadrature axes, alternating bit patterns
  task automatic test_reset_increment();
    set_idling(0, 0);
    send_item(sample_t'(0), 1'b0, 1'b1);           // no samples at all
    send_item(sample_t'(0), 1'b1, 1'b1);           // sample and last together, sums zero
    send_item(SAMPLE_MAX, 1'b1, 1'b1);
    send_item(SAMPLE_MIN, 1'b1, 1'b0);
    send_item(sample_t'(-1), 1'b0, 1'b0);          // ignored item
    send_item(sample_t'(123), 1'b0, 1'b1);         // pi rounds to -pi
    send_item(sample_t'(0), 1'b1, 1'b0);           // +pi/2: only the sine term
    send_item(SAMPLE_MAX, 1'b1, 1'b0);
    send_item(sample_t'(0), 1'b1, 1'b0);
    send_item(SAMPLE_MIN, 1'b1, 1'b1);
    send_item(sample_t'(0), 1'b1, 1'b0);           // -pi/2
    send_item(SAMPLE_MIN, 1'b1, 1'b0);
    send_item(sample_t'(0), 1'b1, 1'b0);
    send_item(SAMPLE_MAX, 1'b1, 1'b1);
    send_item(sample_t'(12'h555), 1'b1, 1'b0);
    send_item(sample_t'(12'hAAA), 1'b1, 1'b0);
    send_item(sample_t'(0), 1'b0, 1'b0);
    send_item(sample_t'(0), 1'b0, 1'b1);
  endtask

  task automatic test_increment_extremes();
    set_idling(0, 0);
    write_increment(32'h0000_0000);
    send_item(SAMPLE_MIN, 1'b1, 1'b0);
    send_item(sample_t'(100), 1'b1, 1'b0);
    send_item(sample_t'(-7), 1'b1, 1'b1);
    write_increment(32'hFFFF_FFFF);                // phase walks backwards
    send_item(SAMPLE_MAX, 1'b1, 1'b0);
    send_item(sample_t'(-1000), 1'b1, 1'b0);
    send_item(sample_t'(1500), 1'b1, 1'b0);
    send_item(sample_t'(0), 1'b0, 1'b1);
    write_increment(HALF_TURN);
    send_item(SAMPLE_MAX, 1'b1, 1'b0);
    send_item(SAMPLE_MIN, 1'b1, 1'b0);
    send_item(SAMPLE_MAX, 1'b1, 1'b1);
  endtask

  // mostly well-formed bursts of random content; ignored items mixed in,
  // last either on the final sample or as an item of its own
  task automatic run_bursts(input int target, input bit pause_midway);
    int counted, len, k;
    bit separate_last, paused;
    counted = 0;
    paused  = 1'b0;
    while (counted < target) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(13, 64);
      separate_last = (len == 0) || $urandom_range(1);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) send_item(pick_sample(), 1'b0, 1'b0);
        send_item(pick_sample(), 1'b1, !separate_last && k == len - 1);
        counted++;
      end
      if (separate_last) begin
        send_item(pick_sample(), 1'b0, 1'b1);
        counted++;
      end
      if (pause_midway && !paused && counted >= target / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0);
    write_increment($urandom);
    run_bursts(450, 1'b0);
    set_idling(67, 0);
    write_increment(PHASE_INC_RESET);
    run_bursts(450, 1'b1);
    set_idling(0, 67);
    write_increment($urandom_range(32'h00FF_FFFF));   // slow carrier drift
    run_bursts(450, 1'b0);
    set_idling(6, 6);
    write_increment($urandom);
    run_bursts(450, 1'b0);
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.sample     <= '0;
    in_if.has_sample <= 1'b0;
    in_if.last       <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_increment();
    test_increment_extremes();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
